@@ rtl/core/ntpta_pkg.sv @@
package ntpta_pkg;

	localparam int NUM_STAGES = 11;
	localparam int NUM_DIGITS = 4;
	localparam int DIG_W      = 11;
	localparam int REM_W      = 21;
	localparam int QUOT_W     = 33;

	// Request kinds.
	localparam logic REQ_ADD     = 1'b0;
	localparam logic REQ_ELAPSED = 1'b1;

	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
	// 10^9 is 2^9 times this odd factor; the division works on it alone.
	localparam logic [REM_W-1:0] DIV_ODD = 21'd1953125;
	// floor(2^32 / DIV_ODD): underestimates a digit quotient by at most one.
	localparam logic [11:0] DIG_RECIP = 12'd2199;
	// floor(2^53 / DIV_ODD): underestimates a fraction quotient by at most one.
	localparam logic [32:0] FRAC_RECIP = 33'h1_12E0_BE82;

	typedef struct packed {
		logic en_a;
		logic en_b;
	} ntpta_step_en_t;

	function automatic logic [29:0] frac_to_ns(input logic [31:0] frac);
		logic [61:0] prod;
		prod = {30'd0, frac} * {32'd0, NS_PER_SEC};
		return prod[61:32];
	endfunction

endpackage

@@ rtl/core/ntpta_if.sv @@
interface ntpta_req_if;
	import ntpta_pkg::*;

	logic        valid;
	logic        ready;
	logic        req_type;
	logic [63:0] stamp_a;
	logic [63:0] stamp_b;
	logic [62:0] offset_ns;

	modport source (output valid, req_type, stamp_a, stamp_b, offset_ns, input ready);
	modport sink (input valid, req_type, stamp_a, stamp_b, offset_ns, output ready);
endinterface

interface ntpta_rsp_if;
	import ntpta_pkg::*;

	logic        valid;
	logic        ready;
	logic [63:0] stamp_out;
	logic [61:0] elapsed_ns;
	logic        bad_order;

	modport source (output valid, stamp_out, elapsed_ns, bad_order, input ready);
	modport sink (input valid, stamp_out, elapsed_ns, bad_order, output ready);
endinterface

@@ rtl/core/ntp_timestamp_arithmetic.sv @@
// Throughput: one request word per cycle while the output is not stalled; the
// offset division by 10^9 runs as four 11-bit long-division digits of two
// stages each, all pipelined.
// A stalled output holds its word; earlier stages keep filling any bubbles.
// Reset clears only the stage valid bits; data registers are not reset.
module ntp_timestamp_arithmetic (
	input  logic         clk,
	input  logic         arst_n,
	ntpta_req_if.sink    req,
	ntpta_rsp_if.source  rsp
);
	import ntpta_pkg::*;

	typedef struct packed {
		logic              req_type;
		logic [62:0]       ns;
		logic [31:0]       sec_a;
		logic [29:0]       fns;
		logic [QUOT_W-1:0] quot;
	} car_t;

	typedef struct packed {
		logic        bad;
		logic [61:0] diff;
	} ela_t;

	logic [NUM_STAGES:1] vld_s;
	logic [NUM_STAGES:1] en;

	car_t car_s [1:8];

	logic [DIG_W-1:0] dig_q [NUM_DIGITS];
	logic [REM_W-1:0] dig_r [NUM_DIGITS];

	// Elapsed path.
	logic [29:0]        nb_s1;
	logic [31:0]        sb_s1;
	logic               eq_s1;
	logic               bad_s2;
	logic [31:0]        ds_s2;
	logic signed [30:0] dn_s2;
	logic               bad_s3;
	logic [61:0]        prod_s3;
	logic signed [30:0] dn_s3;
	ela_t               ela_s [4:10];

	// Add path after the division.
	logic [29:0] ns_rem;
	logic [30:0] sum9;
	logic        carry9;
	logic [31:0] q_low;
	logic        type_s9;
	logic [29:0] rem_s9;
	logic [31:0] secs_s9;
	logic [62:0] frac_prod;
	logic        type_s10;
	logic [29:0] rem_s10;
	logic [31:0] secs_s10;
	logic [31:0] qf_s10;
	logic [52:0] frac_back;
	logic [52:0] frac_diff;
	logic        frac_fix;

	logic [63:0] stamp_out_s11;
	logic [61:0] elapsed_s11;
	logic        bad_s11;

	// A stage takes a new word when it is empty or its word moves on.
	assign en[NUM_STAGES] = !vld_s[NUM_STAGES] || rsp.ready;
	for (genvar k = 1; k < NUM_STAGES; k++) begin : g_en
		assign en[k] = !vld_s[k] || en[k+1];
	end

	assign req.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= req.valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Stage 1: fraction conversions and the stamp compare.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			car_s[1].req_type <= req.req_type;
			car_s[1].ns       <= req.offset_ns;
			car_s[1].sec_a    <= req.stamp_a[63:32];
			car_s[1].fns      <= frac_to_ns(req.stamp_a[31:0]);
			car_s[1].quot     <= '0;
			nb_s1             <= frac_to_ns(req.stamp_b[31:0]);
			sb_s1             <= req.stamp_b[63:32];
			eq_s1             <= (req.stamp_a == req.stamp_b);
		end
	end

	// Stages 2 to 8 carry the word; each digit's quotient joins the word
	// one stage after that digit completes.
	for (genvar k = 2; k <= 8; k++) begin : g_car
		if (k % 2 == 1) begin : g_odd
			always_ff @(posedge clk) begin
				if (en[k]) begin
					car_s[k] <= {car_s[k-1].req_type, car_s[k-1].ns, car_s[k-1].sec_a,
						car_s[k-1].fns,
						car_s[k-1].quot[QUOT_W-DIG_W-1:0], dig_q[(k-3)/2]};
				end
			end
		end else begin : g_even
			always_ff @(posedge clk) begin
				if (en[k]) begin
					car_s[k] <= car_s[k-1];
				end
			end
		end
	end

	// Long division of offset_ns[62:9] by DIV_ODD, eleven bits per digit.
	for (genvar d = 0; d < NUM_DIGITS; d++) begin : g_dig
		ntpta_step_en_t   step_en;
		logic [REM_W-1:0] rem_in;
		logic [DIG_W-1:0] chunk;

		assign step_en.en_a = en[2*d+1];
		assign step_en.en_b = en[2*d+2];

		if (d == 0) begin : g_first
			assign rem_in = {{(REM_W-10){1'b0}}, req.offset_ns[62:53]};
			assign chunk  = req.offset_ns[52:42];
		end else begin : g_next
			assign rem_in = dig_r[d-1];
			assign chunk  = car_s[2*d].ns[52-DIG_W*d -: DIG_W];
		end

		ntpta_digit u_digit (
			.clk     (clk),
			.step_en (step_en),
			.rem_in  (rem_in),
			.chunk   (chunk),
			.quo_out (dig_q[d]),
			.rem_out (dig_r[d])
		);
	end

	// Elapsed path: order check, then seconds times 10^9, then the sum.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			bad_s2 <= (sb_s1 < car_s[1].sec_a)
				|| (sb_s1 == car_s[1].sec_a && nb_s1 < car_s[1].fns) || eq_s1;
			ds_s2  <= sb_s1 - car_s[1].sec_a;
			dn_s2  <= $signed({1'b0, nb_s1}) - $signed({1'b0, car_s[1].fns});
		end
		if (en[3]) begin
			bad_s3  <= bad_s2;
			prod_s3 <= {30'd0, ds_s2} * {32'd0, NS_PER_SEC};
			dn_s3   <= dn_s2;
		end
		if (en[4]) begin
			ela_s[4].bad  <= bad_s3;
			ela_s[4].diff <= prod_s3 + {{31{dn_s3[30]}}, dn_s3};
		end
		for (int k = 5; k <= 10; k++) begin
			if (en[k]) begin
				ela_s[k] <= ela_s[k-1];
			end
		end
	end

	// Stage 9: add the fraction nanoseconds to the offset remainder.
	assign ns_rem = {dig_r[NUM_DIGITS-1], car_s[8].ns[8:0]};
	assign sum9   = {1'b0, ns_rem} + {1'b0, car_s[8].fns};
	assign carry9 = (sum9 >= {1'b0, NS_PER_SEC});
	assign q_low  = {car_s[8].quot[31-DIG_W:0], dig_q[NUM_DIGITS-1]};

	always_ff @(posedge clk) begin
		if (en[9]) begin
			type_s9 <= car_s[8].req_type;
			rem_s9  <= carry9 ? 30'(sum9 - {1'b0, NS_PER_SEC}) : sum9[29:0];
			secs_s9 <= car_s[8].sec_a + q_low + {31'd0, carry9};
		end
	end

	// Stage 10: estimate of (rem << 32) / 10^9.
	assign frac_prod = {33'd0, rem_s9} * {30'd0, FRAC_RECIP};

	always_ff @(posedge clk) begin
		if (en[10]) begin
			type_s10 <= type_s9;
			rem_s10  <= rem_s9;
			secs_s10 <= secs_s9;
			qf_s10   <= frac_prod[61:30];
		end
	end

	// Stage 11: correct the estimate and form the result word.
	assign frac_back = {{REM_W{1'b0}}, qf_s10} * {32'd0, DIV_ODD};
	assign frac_diff = {rem_s10, 23'd0} - frac_back;
	assign frac_fix  = (frac_diff >= {32'd0, DIV_ODD});

	always_ff @(posedge clk) begin
		if (en[11]) begin
			if (type_s10 == REQ_ADD) begin
				stamp_out_s11 <= {secs_s10, qf_s10 + {31'd0, frac_fix}};
				elapsed_s11   <= '0;
				bad_s11       <= 1'b0;
			end else begin
				stamp_out_s11 <= '0;
				elapsed_s11   <= ela_s[10].bad ? 62'd0 : ela_s[10].diff;
				bad_s11       <= ela_s[10].bad;
			end
		end
	end

	assign rsp.valid      = vld_s[NUM_STAGES];
	assign rsp.stamp_out  = stamp_out_s11;
	assign rsp.elapsed_ns = elapsed_s11;
	assign rsp.bad_order  = bad_s11;
endmodule

@@ rtl/core/ntpta_digit.sv @@
module ntpta_digit (
	input  logic                           clk,
	input  ntpta_pkg::ntpta_step_en_t      step_en,
	input  logic [ntpta_pkg::REM_W-1:0]    rem_in,
	input  logic [ntpta_pkg::DIG_W-1:0]    chunk,
	output logic [ntpta_pkg::DIG_W-1:0]    quo_out,
	output logic [ntpta_pkg::REM_W-1:0]    rem_out
);
	import ntpta_pkg::*;

	logic [REM_W+DIG_W-1:0]   t_c;
	logic [REM_W+DIG_W+11:0]  est_prod;
	logic [REM_W+DIG_W-1:0]   t_s1;
	logic [DIG_W-1:0]         qe_s1;
	logic [REM_W+DIG_W-1:0]   back_prod;
	logic [REM_W+DIG_W-1:0]   diff_full;
	logic [REM_W:0]           diff;
	logic                     fix;
	logic [REM_W-1:0]         rem_s2;
	logic [DIG_W-1:0]         quo_s2;

	// Since rem_in is below the divisor, t_c / DIV_ODD fits one digit.
	assign t_c      = {rem_in, chunk};
	assign est_prod = {12'd0, t_c} * {{(REM_W + DIG_W){1'b0}}, DIG_RECIP};

	always_ff @(posedge clk) begin
		if (step_en.en_a) begin
			t_s1  <= t_c;
			qe_s1 <= est_prod[REM_W+DIG_W+DIG_W-1:REM_W+DIG_W];
		end
	end

	assign back_prod = {{REM_W{1'b0}}, qe_s1} * {{DIG_W{1'b0}}, DIV_ODD};
	assign diff_full = t_s1 - back_prod;
	assign diff      = diff_full[REM_W:0];
	assign fix       = (diff >= {1'b0, DIV_ODD});

	always_ff @(posedge clk) begin
		if (step_en.en_b) begin
			rem_s2 <= fix ? REM_W'(diff - {1'b0, DIV_ODD}) : diff[REM_W-1:0];
			quo_s2 <= qe_s1 + {{(DIG_W-1){1'b0}}, fix};
		end
	end

	assign quo_out = quo_s2;
	assign rem_out = rem_s2;
endmodule

@@ verif/ntpta_result_checker.sv @@
module ntpta_result_checker (
	input  logic  clk,
	input  logic  arst_n,
	ntpta_req_if  req,
	ntpta_rsp_if  rsp,
	output int    mismatches,
	output int    awaited,
	output int    checked,
	output int    rejected
);
	import ntpta_pkg::*;

	typedef struct packed {
		logic [63:0] stamp_out;
		logic [61:0] elapsed_ns;
		logic        bad_order;
	} ntp_result_t;

	localparam logic [63:0] NS_WIDE = 64'(NS_PER_SEC);

	// Results owed by the block, oldest request first.
	ntp_result_t awaited_results[$];

	function automatic logic [29:0] fraction_ns(input logic [31:0] frac);
		logic [63:0] prod;
		prod = {32'd0, frac} * NS_WIDE;
		return prod[61:32];
	endfunction

	function automatic ntp_result_t predict_ntp_op(input logic kind, input logic [63:0] a,
			input logic [63:0] b, input logic [62:0] off);
		ntp_result_t res;
		logic [63:0] total;
		logic [63:0] carry;
		logic [63:0] rem;
		logic [63:0] frac_new;
		logic [31:0] secs;
		logic [29:0] ns_a;
		logic [29:0] ns_b;
		logic [63:0] diff;
		logic        bad;
		res = '0;
		if (kind == REQ_ADD) begin
			total = {34'd0, fraction_ns(a[31:0])} + {1'b0, off};
			carry = total / NS_WIDE;
			rem = total % NS_WIDE;
			secs = a[63:32] + carry[31:0];
			frac_new = (rem << 32) / NS_WIDE;
			res.stamp_out = {secs, frac_new[31:0]};
		end else begin
			ns_a = fraction_ns(a[31:0]);
			ns_b = fraction_ns(b[31:0]);
			bad = (b[63:32] < a[63:32]) || (b[63:32] == a[63:32] && ns_b < ns_a) || (a == b);
			diff = '0;
			if (!bad) begin
				diff = ({32'd0, b[63:32]} * NS_WIDE + {34'd0, ns_b})
					- ({32'd0, a[63:32]} * NS_WIDE + {34'd0, ns_a});
			end
			res.elapsed_ns = diff[61:0];
			res.bad_order = bad;
		end
		return res;
	endfunction

	task automatic flag_field(input string field, input logic [63:0] want, input logic [63:0] got);
		if (mismatches < 10) begin
			$display("[%0t] %s mismatch: expected %h, got %h", $realtime, field, want, got);
		end
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		ntp_result_t want;
		if (!arst_n) begin
			awaited_results.delete();
			mismatches = 0;
			checked = 0;
			rejected = 0;
			awaited <= 0;
		end else begin
			if (req.valid && req.ready) begin
				awaited_results.push_back(predict_ntp_op(req.req_type, req.stamp_a,
					req.stamp_b, req.offset_ns));
			end
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					flag_field("unexpected word, stamp_out", 64'd0, rsp.stamp_out);
				end else begin
					want = awaited_results.pop_front();
					checked++;
					if (want.bad_order)
						rejected++;
					if (rsp.stamp_out !== want.stamp_out)
						flag_field("stamp_out", want.stamp_out, rsp.stamp_out);
					if (rsp.elapsed_ns !== want.elapsed_ns)
						flag_field("elapsed_ns", {2'b0, want.elapsed_ns}, {2'b0, rsp.elapsed_ns});
					if (rsp.bad_order !== want.bad_order)
						flag_field("bad_order", {63'd0, want.bad_order}, {63'd0, rsp.bad_order});
				end
			end
			awaited <= awaited_results.size();
		end
	end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
	import ntpta_pkg::*;

	localparam logic [62:0] OFFSET_MAX = '1;
	localparam logic [63:0] STAMP_MAX = '1;
	localparam int RANDOM_PER_PHASE = 138;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   stall_pct;
	int   n_add;
	int   n_elapsed;
	int   mismatches;
	int   awaited;
	int   checked;
	int   rejected;

	ntpta_req_if req_ch();
	ntpta_rsp_if rsp_ch();

	ntp_timestamp_arithmetic u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ntpta_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.awaited    (awaited),
		.checked    (checked),
		.rejected   (rejected)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2400000;
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic logic [63:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	task automatic send_req(input logic kind, input logic [63:0] a, input logic [63:0] b,
			input logic [62:0] off);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= kind;
		req_ch.stamp_a   <= a;
		req_ch.stamp_b   <= b;
		req_ch.offset_ns <= off;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (kind == REQ_ADD)
			n_add++;
		else
			n_elapsed++;
	endtask

	initial begin : stimulus
		logic        kind;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] spare;
		logic [62:0] off;
		int          mode;
		arst_n = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		n_add = 0;
		n_elapsed = 0;
		req_ch.valid     <= 1'b0;
		req_ch.req_type  <= REQ_ADD;
		req_ch.stamp_a   <= '0;
		req_ch.stamp_b   <= '0;
		req_ch.offset_ns <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Field extremes, seconds wrap and fraction truncation on the add side.
		send_req(REQ_ADD, 64'h0, STAMP_MAX, 63'h0);
		send_req(REQ_ADD, STAMP_MAX, 64'h0, 63'h0);
		send_req(REQ_ADD, STAMP_MAX, 64'h0, 63'd1);
		send_req(REQ_ADD, STAMP_MAX, STAMP_MAX, OFFSET_MAX);
		send_req(REQ_ADD, 64'h0, 64'h0, OFFSET_MAX);
		send_req(REQ_ADD, 64'h0000_0001_8000_0000, 64'h0, 63'd999_999_999);
		send_req(REQ_ADD, 64'h0, 64'h0, 63'd1_000_000_000);
		send_req(REQ_ADD, 64'hFFFF_FFFF_0000_0000, 64'h0, 63'd5_000_000_000);
		send_req(REQ_ADD, 64'h0000_0000_0000_0001, 64'h0, 63'h0);
		// Elapsed: identical stamps, earlier second stamp, equal truncated time, widest span.
		send_req(REQ_ELAPSED, 64'h1234_5678_9ABC_DEF0, 64'h1234_5678_9ABC_DEF0, OFFSET_MAX);
		send_req(REQ_ELAPSED, STAMP_MAX, STAMP_MAX, 63'h0);
		send_req(REQ_ELAPSED, 64'h0000_0010_0000_0000, 64'h0000_000F_FFFF_FFFF, 63'h0);
		send_req(REQ_ELAPSED, 64'h0000_0010_8000_0000, 64'h0000_0010_4000_0000, 63'h0);
		send_req(REQ_ELAPSED, 64'h0000_0005_0000_0000, 64'h0000_0005_0000_0001, 63'h0);
		send_req(REQ_ELAPSED, 64'h0000_0005_0000_0001, 64'h0000_0005_0000_0000, 63'h0);
		send_req(REQ_ELAPSED, 64'h0, STAMP_MAX, OFFSET_MAX);
		send_req(REQ_ELAPSED, STAMP_MAX, 64'h0, 63'h0);
		send_req(REQ_ELAPSED, 64'h0000_0010_4000_0000, 64'h0000_0010_8000_0000, 63'h0);
		send_req(REQ_ELAPSED, 64'h0, 64'h0000_0001_0000_0000, 63'h0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					send_idle_pct = 74;
					stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct <= 74;
				end
				default: begin
					send_idle_pct = 25;
					stall_pct <= 25;
				end
			endcase
			repeat (RANDOM_PER_PHASE) begin
				kind = 1'($urandom_range(0, 1));
				a = rand_word();
				b = rand_word();
				spare = rand_word();
				off = spare[62:0];
				mode = $urandom_range(0, 9);
				if (kind == REQ_ADD) begin
					case (mode)
						0, 1, 2: off = 63'($urandom_range(0, 2_000_000_000));
						3: off = OFFSET_MAX - 63'($urandom_range(0, 1000));
						4: begin
							a[63:32] = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
							off = 63'($urandom_range(0, 20)) * 63'd500_000_000;
						end
						5: off = 63'($urandom_range(0, 40)) * 63'(NS_PER_SEC);
						6: begin
							a[31:0] = 32'hFFFF_FFFF - 32'($urandom_range(0, 7));
							off = 63'($urandom_range(0, 3));
						end
						default: ;
					endcase
				end else begin
					// Mostly stamps close to each other, so both orderings and ties show up.
					case (mode)
						0, 1: ;
						2, 3: b = a + {24'd0, spare[39:0]};
						4: b = {a[63:32], b[31:0]};
						5: b = a;
						6: b = a + 64'($urandom_range(1, 4));
						7: b = a - 64'($urandom_range(1, 4));
						8: b = a - {44'd0, spare[19:0]};
						default: b = {a[63:32] + 32'($urandom_range(0, 2)), b[31:0]};
					endcase
				end
				send_req(kind, a, b, off);
			end
		end
		req_ch.valid <= 1'b0;

		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d requests (%0d add, %0d elapsed) under four pacing mixes.",
			n_add + n_elapsed, n_add, n_elapsed);
		$display("Checked %0d result words; %0d elapsed requests were rejected for order.",
			checked, rejected);
		if (mismatches == 0 && awaited == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ ntp_timestamp_arithmetic.f @@
rtl/core/ntpta_pkg.sv
rtl/core/ntpta_if.sv
rtl/core/ntpta_digit.sv
rtl/core/ntp_timestamp_arithmetic.sv
verif/ntpta_result_checker.sv
verif/tb_top.sv
